FILE: rtl/core/readout_chips_in_window_assert.svh
// Assertion helpers shared by the readout chip window logic.
// Every check is clocked on the rising edge and disabled while reset is low.
`ifndef READOUT_CHIPS_IN_WINDOW_ASSERT_SVH
`define READOUT_CHIPS_IN_WINDOW_ASSERT_SVH

// Same-cycle implication.
`define RCIW_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RCIW_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/rciw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rciw_pkg;

    // Parameter defaults
    localparam int DEF_STRIPS_PER_CHIP    = 128;
    localparam int DEF_COEF_FRACTION_BITS = 20;

    // Field widths
    localparam int COORD_W     = 17;
    localparam int HALF_W      = 16;
    localparam int COUNT_W     = 10;
    localparam int CFG_DATA_W  = 16;
    localparam int CHIP_NUM_W  = 4;
    localparam int IN_TDATA_W  = 72;   // 4 x 17 bits, padded to bytes
    localparam int OUT_TDATA_W = 8;    // 4 bits, padded to a byte

    // Sensor geometry
    localparam int CHANNELS_PER_SIDE = 768;
    localparam int N_FLIP_BASE       = 1535;
    localparam int OFFSET_L5         = 382;
    localparam int OFFSET_L6         = 385;
    localparam int N_SHIFT           = 4;
    localparam int MAX_OUT           = 8;
    localparam int NUM_CORNERS       = 4;

    // Stereo coefficients as num / den, scaled by 2^F at elaboration
    localparam longint CX_NUM = 10526;
    localparam longint CX_DEN = 1000000;
    localparam longint CZ_NUM = 7895;
    localparam longint CZ_DEN = 100000000;
    localparam longint CN_NUM = 3684;
    localparam longint CN_DEN = 10000000;

    // Register reset values
    localparam logic [0:0]         RST_LAYER_SIX    = 1'b0;
    localparam logic [HALF_W-1:0]  RST_HALF_WIDTH_X = 16'd36500;
    localparam logic [HALF_W-1:0]  RST_HALF_WIDTH_Z = 16'd20000;
    localparam logic [COUNT_W-1:0] RST_STRIP_COUNT  = 10'd768;

    typedef enum logic [1:0] {
        CFG_LAYER_SIX    = 2'd0,
        CFG_HALF_WIDTH_X = 2'd1,
        CFG_HALF_WIDTH_Z = 2'd2,
        CFG_STRIP_COUNT  = 2'd3
    } cfg_index_t;

endpackage

`default_nettype wire

FILE: rtl/core/readout_chips_in_window.sv
// Readout chips under a window on a double-sided strip sensor.
// Flow: a request is registered in stages 1 to 4 before it loads the result list.
// Throughput: while s_tready is high, one window request per cycle enters a 4-stage
//   pipeline; results leave one per cycle while m_tready is high, 1 to 8 per window.
// Reset: synchronous, active low; clears all valid flags and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module readout_chips_in_window #(
    parameter int STRIPS_PER_CHIP    = rciw_pkg::DEF_STRIPS_PER_CHIP,
    parameter int COEF_FRACTION_BITS = rciw_pkg::DEF_COEF_FRACTION_BITS
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration write port
    input  wire logic                              cfg_we,
    input  wire rciw_pkg::cfg_index_t              cfg_index,
    input  wire logic [rciw_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // window request
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // tdata: window_z_low[16:0], window_z_high[33:17], window_x_low[50:34],
    //        window_x_high[67:51], zero pad [71:68]
    input  wire logic [rciw_pkg::IN_TDATA_W-1:0]   s_tdata,
    // chip results
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // tdata: chip_number[3:0], zero pad [7:4]
    output logic [rciw_pkg::OUT_TDATA_W-1:0]       m_tdata,
    output logic                                   m_tlast,    // last_chip
    output logic [0:0]                             m_tuser     // window_empty
);

    import rciw_pkg::*;

    `include "readout_chips_in_window_assert.svh"

    // ------------------------------------------------------------------
    // Derived constants
    // ------------------------------------------------------------------
    localparam int F        = COEF_FRACTION_BITS;
    localparam int COEF_W   = F - 5;                 // CX < 2^(F-6), signed
    localparam int PROD_W   = COORD_W + COEF_W;
    localparam int ACC_W    = F + 13;                // |P|,|N| < 2^(F+11)
    localparam int STRIP_W  = ACC_W - F;             // integer part of P / N
    localparam int CHAN_W   = $clog2(CHANNELS_PER_SIDE);
    localparam int NUM_W    = $clog2(N_FLIP_BASE + 1);
    localparam int CHIP_W   = $clog2(N_FLIP_BASE / STRIPS_PER_CHIP + 1);
    localparam int IDX_W    = $clog2(MAX_OUT);
    localparam int CNT_W    = $clog2(MAX_OUT + 1);

    localparam longint ONE_L  = longint'(1) << F;
    localparam longint CX_VAL = ((CX_NUM << F) + CX_DEN / 2) / CX_DEN;
    localparam longint CZ_VAL = ((CZ_NUM << F) + CZ_DEN / 2) / CZ_DEN;
    localparam longint CN_VAL = ((CN_NUM << F) + CN_DEN / 2) / CN_DEN;

    localparam logic signed [COEF_W-1:0] CX = COEF_W'(CX_VAL);
    localparam logic signed [COEF_W-1:0] CZ = COEF_W'(CZ_VAL);
    localparam logic signed [COEF_W-1:0] CN = COEF_W'(CN_VAL);

    localparam logic signed [ACC_W-1:0] OFF_L5    = ACC_W'(longint'(OFFSET_L5) * ONE_L);
    localparam logic signed [ACC_W-1:0] OFF_L6    = ACC_W'(longint'(OFFSET_L6) * ONE_L);
    localparam logic signed [ACC_W-1:0] SHIFT_ONE = ACC_W'(longint'(N_SHIFT) * ONE_L);
    localparam logic signed [ACC_W-1:0] NEG_ONE   = ACC_W'(-ONE_L);

    // Exact divide by STRIPS_PER_CHIP for values below 2^NUM_W:
    // q = (n * ceil(2^K / d)) >> K with K = NUM_W + ceil(log2 d).
    localparam int     RECIP_SHIFT = NUM_W + $clog2(STRIPS_PER_CHIP);
    localparam longint RECIP_L     = ((longint'(1) << RECIP_SHIFT) + STRIPS_PER_CHIP - 1)
                                     / STRIPS_PER_CHIP;
    localparam int     RECIP_W     = $clog2(RECIP_L + 1);
    localparam int     QPROD_W     = NUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

    localparam logic [NUM_W-1:0]   FLIP_BASE = NUM_W'(N_FLIP_BASE);
    localparam logic [COUNT_W-1:0] CHAN_LIM  = COUNT_W'(CHANNELS_PER_SIDE);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic                layer_six_reg;
    logic [HALF_W-1:0]   half_width_x_reg;
    logic [HALF_W-1:0]   half_width_z_reg;
    logic [COUNT_W-1:0]  strip_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            layer_six_reg    <= RST_LAYER_SIX;
            half_width_x_reg <= RST_HALF_WIDTH_X;
            half_width_z_reg <= RST_HALF_WIDTH_Z;
            strip_count_reg  <= RST_STRIP_COUNT;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_LAYER_SIX:    layer_six_reg    <= cfg_wdata[0];
                CFG_HALF_WIDTH_X: half_width_x_reg <= cfg_wdata[HALF_W-1:0];
                CFG_HALF_WIDTH_Z: half_width_z_reg <= cfg_wdata[HALF_W-1:0];
                CFG_STRIP_COUNT:  strip_count_reg  <= cfg_wdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control. Each stage loads when it is empty or when its
    // content moves on in the same cycle; the result list frees up on its
    // final beat, so a new window follows the last chip without a gap.
    // ------------------------------------------------------------------
    logic s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg;
    logic list_v_reg;
    logic en1, en2, en3, en4;
    logic list_load, beat, beat_last;

    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] last_idx_reg;

    assign beat      = list_v_reg && m_tready;
    assign beat_last = beat && (idx_reg == last_idx_reg);
    assign list_load = s4_v_reg && (!list_v_reg || beat_last);
    assign en4       = !s4_v_reg || list_load;
    assign en3       = !s3_v_reg || en4;
    assign en2       = !s2_v_reg || en3;
    assign en1       = !s1_v_reg || en2;
    assign s_tready  = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
        end else begin
            if (en1) s1_v_reg <= s_tvalid;
            if (en2) s2_v_reg <= s1_v_reg;
            if (en3) s3_v_reg <= s2_v_reg;
            if (en4) s4_v_reg <= s3_v_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: window bounds as received
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] z_lo_reg, z_hi_reg, x_lo_reg, x_hi_reg;

    always_ff @(posedge aclk) begin
        if (en1) begin
            z_lo_reg <= s_tdata[0*COORD_W +: COORD_W];
            z_hi_reg <= s_tdata[1*COORD_W +: COORD_W];
            x_lo_reg <= s_tdata[2*COORD_W +: COORD_W];
            x_hi_reg <= s_tdata[3*COORD_W +: COORD_W];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: clamp to the half extents, flag bounds still off the sensor,
    // and form the coefficient products (index 0 = low bound, 1 = high).
    // ------------------------------------------------------------------
    logic signed [COORD_W:0]   hx_s, hz_s, neg_hx, neg_hz;
    logic signed [COORD_W-1:0] xc [2];
    logic signed [COORD_W-1:0] zc [2];
    logic                      xbad_next [2];
    logic                      zbad_next [2];

    logic signed [PROD_W-1:0]  px_reg [2];
    logic signed [PROD_W-1:0]  pz_reg [2];
    logic signed [PROD_W-1:0]  pn_reg [2];
    logic                      xbad_reg [2];
    logic                      zbad_reg [2];

    always_comb begin
        hx_s   = signed'({2'b00, half_width_x_reg});
        hz_s   = signed'({2'b00, half_width_z_reg});
        neg_hx = -hx_s;
        neg_hz = -hz_s;
        // only the low bound is raised and only the high bound lowered
        xc[0] = (x_lo_reg < neg_hx) ? COORD_W'(neg_hx) : x_lo_reg;
        xc[1] = (x_hi_reg > hx_s)   ? COORD_W'(hx_s)   : x_hi_reg;
        zc[0] = (z_lo_reg < neg_hz) ? COORD_W'(neg_hz) : z_lo_reg;
        zc[1] = (z_hi_reg > hz_s)   ? COORD_W'(hz_s)   : z_hi_reg;
        // window wholly beside the sensor
        xbad_next[0] = xc[0] > hx_s;
        xbad_next[1] = xc[1] < neg_hx;
        zbad_next[0] = zc[0] > hz_s;
        zbad_next[1] = zc[1] < neg_hz;
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            for (int k = 0; k < 2; k++) begin
                px_reg[k]   <= CX * xc[k];
                pz_reg[k]   <= CZ * zc[k];
                pn_reg[k]   <= CN * zc[k];
                xbad_reg[k] <= xbad_next[k];
                zbad_reg[k] <= zbad_next[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: stereo formula per corner, truncate toward zero, range check.
    // Corner order: (xlo,zlo) (xlo,zhi) (xhi,zlo) (xhi,zhi).
    // ------------------------------------------------------------------
    logic [COUNT_W-1:0]        lim;
    logic [STRIP_W-1:0]        lim_w;
    logic signed [ACC_W-1:0]   p_acc [NUM_CORNERS];
    logic signed [ACC_W-1:0]   n_acc [NUM_CORNERS];
    logic                      ok_next [NUM_CORNERS];
    logic [CHAN_W-1:0]         ps_next [NUM_CORNERS];
    logic [CHAN_W-1:0]         ns_next [NUM_CORNERS];

    logic                      ok3_reg [NUM_CORNERS];
    logic [CHAN_W-1:0]         ps_reg  [NUM_CORNERS];
    logic [CHAN_W-1:0]         ns_reg  [NUM_CORNERS];

    always_comb begin
        lim   = (strip_count_reg > CHAN_LIM) ? CHAN_LIM : strip_count_reg;
        lim_w = STRIP_W'(lim);
        for (int i = 0; i < NUM_CORNERS; i++) begin
            if (layer_six_reg) begin
                p_acc[i] = OFF_L6 - ACC_W'(px_reg[i/2]) - ACC_W'(pz_reg[i%2]);
                n_acc[i] = p_acc[i] + ACC_W'(pn_reg[i%2]) + SHIFT_ONE;
            end else begin
                p_acc[i] = OFF_L5 + ACC_W'(px_reg[i/2]) - ACC_W'(pz_reg[i%2]);
                n_acc[i] = p_acc[i] + ACC_W'(pn_reg[i%2]) - SHIFT_ONE;
            end
            // a negative value above -1.0 truncates to strip 0
            ok_next[i] = !xbad_reg[i/2] && !zbad_reg[i%2]
                && (p_acc[i][ACC_W-1] ? (p_acc[i] > NEG_ONE)
                                      : (p_acc[i][ACC_W-1:F] < lim_w))
                && (n_acc[i][ACC_W-1] ? (n_acc[i] > NEG_ONE)
                                      : (n_acc[i][ACC_W-1:F] < lim_w));
            ps_next[i] = p_acc[i][ACC_W-1] ? '0 : p_acc[i][F +: CHAN_W];
            ns_next[i] = n_acc[i][ACC_W-1] ? '0 : n_acc[i][F +: CHAN_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            for (int i = 0; i < NUM_CORNERS; i++) begin
                ok3_reg[i] <= ok_next[i];
                ps_reg[i]  <= ps_next[i];
                ns_reg[i]  <= ns_next[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: strip to chip by reciprocal multiply; N side counts down.
    // ------------------------------------------------------------------
    logic [NUM_W-1:0]   nflip   [NUM_CORNERS];
    logic [QPROD_W-1:0] pq_prod [NUM_CORNERS];
    logic [QPROD_W-1:0] nq_prod [NUM_CORNERS];

    logic               ok4_reg [NUM_CORNERS];
    logic [CHIP_W-1:0]  pc_reg  [NUM_CORNERS];
    logic [CHIP_W-1:0]  nc_reg  [NUM_CORNERS];

    always_comb begin
        for (int i = 0; i < NUM_CORNERS; i++) begin
            nflip[i]   = FLIP_BASE - NUM_W'(ns_reg[i]);
            pq_prod[i] = QPROD_W'(ps_reg[i]) * QPROD_W'(RECIP);
            nq_prod[i] = QPROD_W'(nflip[i]) * QPROD_W'(RECIP);
        end
    end

    always_ff @(posedge aclk) begin
        if (en4) begin
            for (int i = 0; i < NUM_CORNERS; i++) begin
                ok4_reg[i] <= ok3_reg[i];
                pc_reg[i]  <= pq_prod[i][RECIP_SHIFT +: CHIP_W];
                nc_reg[i]  <= nq_prod[i][RECIP_SHIFT +: CHIP_W];
            end
        end
    end

    // ------------------------------------------------------------------
    // Duplicate removal and packing into the result list. Chips compare at
    // full width, then go out as their low four bits.
    // ------------------------------------------------------------------
    logic [CHIP_NUM_W-1:0] list_next [MAX_OUT];
    logic [CNT_W-1:0]      cnt;
    logic                  dupp, dupn;

    always_comb begin
        cnt = '0;
        for (int k = 0; k < MAX_OUT; k++) list_next[k] = '0;
        for (int i = 0; i < NUM_CORNERS; i++) begin
            dupp = 1'b0;
            dupn = 1'b0;
            for (int j = 0; j < NUM_CORNERS; j++) begin
                if (j < i && ok4_reg[j]) begin
                    if (pc_reg[j] == pc_reg[i]) dupp = 1'b1;
                    if (nc_reg[j] == nc_reg[i]) dupn = 1'b1;
                end
            end
            if (ok4_reg[i]) begin
                if (!dupp) begin
                    list_next[cnt[IDX_W-1:0]] = CHIP_NUM_W'(pc_reg[i]);
                    cnt = cnt + 1'b1;
                end
                if (!dupn) begin
                    list_next[cnt[IDX_W-1:0]] = CHIP_NUM_W'(nc_reg[i]);
                    cnt = cnt + 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result list: drained one chip per beat. An empty window is a single
    // beat with chip 0 and the empty flag set.
    // ------------------------------------------------------------------
    logic [CHIP_NUM_W-1:0] list_reg [MAX_OUT];
    logic                  empty_reg;

    always_ff @(posedge aclk) begin
        if (list_load) begin
            for (int k = 0; k < MAX_OUT; k++) list_reg[k] <= list_next[k];
            empty_reg <= (cnt == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            list_v_reg   <= 1'b0;
            idx_reg      <= '0;
            last_idx_reg <= '0;
        end else if (list_load) begin
            list_v_reg   <= 1'b1;
            idx_reg      <= '0;
            last_idx_reg <= (cnt == '0) ? '0 : IDX_W'(cnt - 1'b1);
        end else if (beat_last) begin
            list_v_reg <= 1'b0;
        end else if (beat) begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    assign m_tvalid = list_v_reg;
    assign m_tdata  = OUT_TDATA_W'(list_reg[idx_reg]);
    assign m_tlast  = (idx_reg == last_idx_reg);
    assign m_tuser  = empty_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `RCIW_ASSERT_IMPL(a_idx_in_list, aclk, aresetn, list_v_reg, idx_reg <= last_idx_reg, "result index past end of list")
    `RCIW_ASSERT_IMPL(a_empty_single, aclk, aresetn, list_v_reg && empty_reg, last_idx_reg == '0 && m_tdata == '0, "empty window must be one zero result")
    `RCIW_ASSERT_NEXT(a_list_drains, aclk, aresetn, beat_last && !s4_v_reg, !list_v_reg, "list still valid after final beat")
    `RCIW_ASSERT_NEXT(a_list_refill, aclk, aresetn, list_load, list_v_reg && idx_reg == '0, "new list must start at its first chip")

endmodule

`default_nettype wire

FILE: sim/chip_window_checker.sv
`timescale 1ns / 1ps

// Watches the window request and chip result channels, predicts the chips
// under each window and compares every result against the oldest prediction.
module chip_window_checker #(
    parameter int STRIPS_PER_CHIP    = rciw_pkg::DEF_STRIPS_PER_CHIP,
    parameter int COEF_FRACTION_BITS = rciw_pkg::DEF_COEF_FRACTION_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  rciw_pkg::cfg_index_t                cfg_index,
    input  logic [rciw_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [rciw_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [rciw_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                                m_tlast,
    input  logic [0:0]                          m_tuser,
    output int                                  mismatches,
    output int                                  outstanding
);
    import rciw_pkg::*;

    localparam longint ONE   = longint'(1) << COEF_FRACTION_BITS;
    localparam longint CX_FP = ((CX_NUM << COEF_FRACTION_BITS) + CX_DEN / 2) / CX_DEN;
    localparam longint CZ_FP = ((CZ_NUM << COEF_FRACTION_BITS) + CZ_DEN / 2) / CZ_DEN;
    localparam longint CN_FP = ((CN_NUM << COEF_FRACTION_BITS) + CN_DEN / 2) / CN_DEN;

    typedef struct packed {
        logic [CHIP_NUM_W-1:0] chip;
        logic                  last;
        logic                  empty;
    } chip_result_t;

    chip_result_t expected_chips[$];

    // shadow copy of the register file
    bit     layer_six;
    longint half_x;
    longint half_z;
    longint strip_count;

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    // P and N chip of one corner; 0 when the corner is off sensor or off strips
    function automatic bit corner_chips(input longint x, input longint z,
                                        output longint p_chip, output longint n_chip);
        longint p, n, ps, ns, lim;
        p_chip = 0;
        n_chip = 0;
        if (x < -half_x || x > half_x || z < -half_z || z > half_z)
            return 0;
        if (layer_six) begin
            p = -CX_FP * x - CZ_FP * z + OFFSET_L6 * ONE;
            n = p + CN_FP * z + N_SHIFT * ONE;
        end else begin
            p = CX_FP * x - CZ_FP * z + OFFSET_L5 * ONE;
            n = p + CN_FP * z - N_SHIFT * ONE;
        end
        ps  = p / ONE;      // truncates toward zero
        ns  = n / ONE;
        lim = (strip_count > CHANNELS_PER_SIDE) ? CHANNELS_PER_SIDE : strip_count;
        if (ps < 0 || ps >= lim || ns < 0 || ns >= lim)
            return 0;
        p_chip = ps / STRIPS_PER_CHIP;
        n_chip = (N_FLIP_BASE - ns) / STRIPS_PER_CHIP;
        return 1;
    endfunction

    function automatic void predict_chips(input logic [IN_TDATA_W-1:0] w);
        longint zl, zh, xl, xh;
        longint cxs[NUM_CORNERS], czs[NUM_CORNERS];
        longint pv[NUM_CORNERS], nv[NUM_CORNERS];
        bit     ok[NUM_CORNERS];
        longint found[$];
        bit     dup_p, dup_n;
        chip_result_t r;
        zl = longint'($signed(w[16:0]));
        zh = longint'($signed(w[33:17]));
        xl = longint'($signed(w[50:34]));
        xh = longint'($signed(w[67:51]));
        if (zl < -half_z) zl = -half_z;
        if (zh > half_z)  zh = half_z;
        if (xl < -half_x) xl = -half_x;
        if (xh > half_x)  xh = half_x;
        cxs = '{xl, xl, xh, xh};
        czs = '{zl, zh, zl, zh};
        for (int i = 0; i < NUM_CORNERS; i++) begin
            ok[i] = corner_chips(cxs[i], czs[i], pv[i], nv[i]);
            if (!ok[i]) continue;
            dup_p = 0;
            dup_n = 0;
            // duplicates compared at full size, before masking
            for (int j = 0; j < i; j++) begin
                if (!ok[j]) continue;
                if (pv[j] == pv[i]) dup_p = 1;
                if (nv[j] == nv[i]) dup_n = 1;
            end
            if (!dup_p) found.push_back(pv[i]);
            if (!dup_n) found.push_back(nv[i]);
        end
        if (found.size() == 0) begin
            r = '{chip: '0, last: 1'b1, empty: 1'b1};
            expected_chips.push_back(r);
        end else begin
            foreach (found[k]) begin
                r.chip  = found[k][CHIP_NUM_W-1:0];
                r.last  = (k == found.size() - 1);
                r.empty = 1'b0;
                expected_chips.push_back(r);
            end
        end
    endfunction

    always @(posedge aclk) begin
        chip_result_t want;
        if (!aresetn) begin
            layer_six   = RST_LAYER_SIX;
            half_x      = RST_HALF_WIDTH_X;
            half_z      = RST_HALF_WIDTH_Z;
            strip_count = RST_STRIP_COUNT;
            expected_chips.delete();
            outstanding <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_chips.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected chip result: expected none, ", $time,
                             "got tdata 0x%02h last %0b empty %0b",
                             m_tdata, m_tlast, m_tuser[0]);
                end else begin
                    want = expected_chips.pop_front();
                    if (m_tdata !== {{(OUT_TDATA_W-CHIP_NUM_W){1'b0}}, want.chip} ||
                        m_tlast !== want.last || m_tuser[0] !== want.empty) begin
                        mismatches++;
                        $display("%0t: chip result mismatch: expected chip %0d last %0b ",
                                 $time, want.chip, want.last,
                                 "empty %0b, got tdata 0x%02h last %0b empty %0b",
                                 want.empty, m_tdata, m_tlast, m_tuser[0]);
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_chips(s_tdata);
            if (cfg_we) begin
                case (cfg_index)
                    CFG_LAYER_SIX:    layer_six   = cfg_wdata[0];
                    CFG_HALF_WIDTH_X: half_x      = cfg_wdata[HALF_W-1:0];
                    CFG_HALF_WIDTH_Z: half_z      = cfg_wdata[HALF_W-1:0];
                    CFG_STRIP_COUNT:  strip_count = cfg_wdata[COUNT_W-1:0];
                    default: ;
                endcase
            end
            outstanding <= expected_chips.size();
        end
    end

endmodule

FILE: sim/readout_chips_in_window_tb.sv
`timescale 1ns / 1ps

// Top of the chip window bench: clock, reset, register settings and window
// requests. All result checking happens in chip_window_checker; this module
// drives stimulus, runs a watchdog and turns the checker's failure count into the verdict.
module readout_chips_in_window_tb;
    import rciw_pkg::*;

    // Worst case is 415 requests x (8 results, each behind a receiver stall,
    // plus sender gaps); this is several times that.
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PER_PH = 50;
    localparam int NUM_PHASES    = 8;

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    cfg_we    = 1'b0;
    cfg_index_t              cfg_index = CFG_LAYER_SIX;
    logic [CFG_DATA_W-1:0]   cfg_wdata = '0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    // tdata: window_z_low, window_z_high, window_x_low, window_x_high, pad
    logic [IN_TDATA_W-1:0]   s_tdata   = '0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    // tdata: chip_number, pad
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic                    m_tlast;
    logic [0:0]              m_tuser;    // window_empty

    int mismatches;
    int outstanding;
    int cycles         = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int half_x         = RST_HALF_WIDTH_X;   // generator's view of the sensor extent
    int half_z         = RST_HALF_WIDTH_Z;

    readout_chips_in_window DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    chip_window_checker chip_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // 4 ns clock
    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // receiver backpressure; a zero percentage keeps tready high
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // watchdog: also catches results that never arrive
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int sat17(input int v);
        if (v > 65535)  return 65535;
        if (v < -65536) return -65536;
        return v;
    endfunction

    // One request; random gaps before it. tvalid is only dropped while idling,
    // so back-to-back requests never lower and raise it in the same step.
    task automatic send_window(input int zl, input int zh, input int xl, input int xh);
        logic [COORD_W-1:0] f_zl, f_zh, f_xl, f_xh;
        f_zl = zl[COORD_W-1:0];
        f_zh = zh[COORD_W-1:0];
        f_xl = xl[COORD_W-1:0];
        f_xh = xh[COORD_W-1:0];
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W-4*COORD_W){1'b0}}, f_xh, f_xl, f_zh, f_zl};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Mostly windows around the sensor with sizes from a few strips up to
    // the whole face; the rest is full-range noise on every field.
    task automatic random_window();
        int cx, cz, dx, dz, reach_x, reach_z, zl, zh, xl, xh, t;
        if ($urandom_range(0, 99) < 20) begin
            send_window(int'($urandom_range(0, 131071)) - 65536,
                        int'($urandom_range(0, 131071)) - 65536,
                        int'($urandom_range(0, 131071)) - 65536,
                        int'($urandom_range(0, 131071)) - 65536);
        end else begin
            reach_x = half_x + 3000;
            reach_z = half_z + 3000;
            cx = int'($urandom_range(0, 2 * reach_x)) - reach_x;
            cz = int'($urandom_range(0, 2 * reach_z)) - reach_z;
            case ($urandom_range(0, 3))
                0:       dx = $urandom_range(0, 200);
                1:       dx = $urandom_range(0, 5000);
                2:       dx = $urandom_range(0, 30000);
                default: dx = $urandom_range(0, 70000);
            endcase
            dz = $urandom_range(0, 25000);
            xl = sat17(cx - dx);
            xh = sat17(cx + dx);
            zl = sat17(cz - dz);
            zh = sat17(cz + dz);
            // occasionally reversed bounds
            if ($urandom_range(0, 9) == 0) begin
                t = xl; xl = xh; xh = t;
            end
            if ($urandom_range(0, 9) == 0) begin
                t = zl; zl = zh; zh = t;
            end
            send_window(zl, zh, xl, xh);
        end
    endtask

    // Drop tvalid, then wait for every predicted chip to come out plus a
    // little pipeline slack before touching registers.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic apply_setting(input bit layer, input int hx, input int hz, input int sc);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_LAYER_SIX;
        cfg_wdata <= CFG_DATA_W'(layer);
        @(posedge aclk);
        cfg_index <= CFG_HALF_WIDTH_X;
        cfg_wdata <= CFG_DATA_W'(hx);
        @(posedge aclk);
        cfg_index <= CFG_HALF_WIDTH_Z;
        cfg_wdata <= CFG_DATA_W'(hz);
        @(posedge aclk);
        cfg_index <= CFG_STRIP_COUNT;
        cfg_wdata <= CFG_DATA_W'(sc);
        @(posedge aclk);
        cfg_we <= 1'b0;
        half_x = hx;
        half_z = hz;
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed requests at reset settings (layer 5, 36500 x 20000, 768 strips),
        // no idling. Order of args: z_low, z_high, x_low, x_high.
        send_window( 65535,  65535,  65535,  65535);   // all max: beside the sensor
        send_window(-65536, -65536, -65536, -65536);   // all min: beside the sensor
        send_window(-65536,  65535, -65536,  65535);   // clamped to the full face
        send_window(     0,      0,      0,      0);   // single point at center
        send_window( 20000, -20000,  30000, -30000);   // reversed bounds
        send_window(-5000,    5000,  40000,  50000);   // wholly right of the sensor
        send_window(-5000,    5000, -50000, -40000);   // wholly left of the sensor
        send_window( 25000,  30000,  -1000,   1000);   // wholly above the sensor
        send_window(-36000, -36000, -36500, -36500);   // corner where P strip goes negative
        send_window(-20000,  20000, -36500,      0);   // left half
        send_window(-20000,  20000,      0,  36500);   // right half
        send_window(-100,      100,  -6300,  -6100);   // narrow window within a single P chip
        send_window(-20000,  20000,  36000,  36500);   // right edge strip
        send_window(-43691,  43690, -43691,  43690);   // alternating bit patterns
        send_window( 43690, -43691,  43690, -43691);
        drain();

        // Register settings, extremes included; idling pattern rotates with the phase.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: apply_setting(1'b1, 36500, 20000, 768);
                1: apply_setting(1'b0, 65535, 65535, 1023);   // strip limit caps at 768
                2: apply_setting(1'b1,     0,     0, 768);    // only the center point
                3: apply_setting(1'b0, 36500, 20000, 0);      // every window empty
                4: apply_setting(1'b1, 65535, 65535, 1023);
                5: apply_setting(1'b0, 20000, 10000, 400);
                6: apply_setting(1'b1, 36500, 20000, 768);
                default: apply_setting(1'b0, 36500, 20000, 768);
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            repeat (RANDOM_PER_PH) random_window();
            drain();
        end

        repeat (20) @(posedge aclk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
